// File: rtl/tlwrr_pkg.sv
// tlwrr_pkg: shared constants and types of the two-list weighted round-robin scheduler
// no dependencies
`timescale 1ns / 1ps
package tlwrr_pkg;
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;
  localparam logic [1:0] FUNC_REMOVE = 2'd3;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_STOP = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] task_id;
    logic [7:0] priority_req;
    logic [1:0] new_status;
    logic       target_queue;
  } req_t;

  typedef struct packed {
    logic [5:0] run_task;
    logic       run_valid;
    logic       switched;
    logic       no_runnable;
  } rsp_t;
endpackage

// File: rtl/tlwrr_if.sv
// tlwrr_if: valid/ready channel carrying one payload
// depends on tlwrr_pkg for payload types
`timescale 1ns / 1ps
interface tlwrr_req_if;
  logic             valid;
  logic             ready;
  tlwrr_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tlwrr_rsp_if;
  logic             valid;
  logic             ready;
  tlwrr_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tlwrr_ram.sv
// tlwrr_ram: generic single-port-write, single-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
module tlwrr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/two_list_weighted_round_robin.sv
// two_list_weighted_round_robin: scheduler top level with list sequencer
// a tick that keeps its task answers without a walk; a reschedule walks the list heads,
//   moving each examined entry to the tail of the other list, in at most two passes
// throughput: one request at a time, ready again in the cycle after the response is taken
// reset: after rst_ni a clearing pass over all MAX_TASKS entries frees them
//   before the first request is taken
`timescale 1ns / 1ps
module two_list_weighted_round_robin #(
  parameter int MAX_TASKS = 64,
  parameter int PRIO_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  tlwrr_req_if.sink   req_i,
  tlwrr_rsp_if.source rsp_o
);
  localparam int IW = $clog2(MAX_TASKS);
  localparam int LW = IW + 1;
  localparam int SW = PRIO_BITS + 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_TASKS);
  localparam logic signed [SW-1:0] SMIN = {1'b1, {PRIO_BITS{1'b0}}};

  // sequencer states
  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DEC   = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;  // read links+status of t
  localparam logic [4:0] S_RDW   = 5'd4;
  localparam logic [4:0] S_UL1   = 5'd5;  // fix prev side
  localparam logic [4:0] S_UL2   = 5'd6;  // fix next side
  localparam logic [4:0] S_AP1   = 5'd7;  // append: link t
  localparam logic [4:0] S_AP2   = 5'd8;  // append: old tail next
  localparam logic [4:0] S_OUT   = 5'd9;
  localparam logic [4:0] S_WHD   = 5'd10; // walk: examine head
  localparam logic [4:0] S_WST   = 5'd11;
  localparam logic [4:0] S_WSW   = 5'd12;
  localparam logic [4:0] S_CHK   = 5'd13; // status of current task
  localparam logic [4:0] S_CHKW  = 5'd14;
  localparam logic [4:0] S_PRIO  = 5'd15; // priority of picked task arrives

  // action after unlink/append chain
  localparam logic [1:0] A_REM  = 2'd0;
  localparam logic [1:0] A_INS  = 2'd1;
  localparam logic [1:0] A_WALK = 2'd2;
  localparam logic [1:0] A_PICK = 2'd3;

  logic [4:0] st_q, st_d;
  logic [1:0] act_q, act_d;
  tlwrr_pkg::req_t rq_q, rq_d;
  tlwrr_pkg::rsp_t rsp;
  logic [IW-1:0] t_q, t_d;
  logic [LW-1:0] p_q, p_d, n_q, n_d;
  logic tqo_q, tqo_d;
  logic [LW-1:0] head_q [2], head_d [2];
  logic [LW-1:0] tail_q [2], tail_d [2];
  logic sel_q, sel_d, aq_q, aq_d;
  logic pass_q, pass_d;
  logic [LW:0] cnt_q, cnt_d;
  logic signed [SW-1:0] slice_q, slice_d;
  logic [IW-1:0] cur_q, cur_d;
  logic cv_q, cv_d;
  logic sw_q, sw_d, none_q, none_d;

  // memories: status, priority, next, prev, queue
  logic st_we, pr_we, nx_we, pv_we, qo_we;
  logic [IW-1:0] st_wa, nx_wa, pv_wa, ra;
  logic [1:0] st_wd, st_rd;
  logic [PRIO_BITS-1:0] pr_rd;
  logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic qo_wd, qo_rd;

  tlwrr_ram #(.Width(2), .Depth(MAX_TASKS)) u_st (.clk_i, .we_i(st_we),
    .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(ra), .rdata_o(st_rd));
  tlwrr_ram #(.Width(PRIO_BITS), .Depth(MAX_TASKS)) u_pr (.clk_i, .we_i(pr_we),
    .waddr_i(t_q), .wdata_i(PRIO_BITS'(rq_q.priority_req)), .raddr_i(ra),
    .rdata_o(pr_rd));
  tlwrr_ram #(.Width(LW), .Depth(MAX_TASKS)) u_nx (.clk_i, .we_i(nx_we),
    .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(ra), .rdata_o(nx_rd));
  tlwrr_ram #(.Width(LW), .Depth(MAX_TASKS)) u_pv (.clk_i, .we_i(pv_we),
    .waddr_i(pv_wa), .wdata_i(pv_wd), .raddr_i(ra), .rdata_o(pv_rd));
  tlwrr_ram #(.Width(1), .Depth(MAX_TASKS)) u_qo (.clk_i, .we_i(qo_we),
    .waddr_i(t_q), .wdata_i(qo_wd), .raddr_i(ra), .rdata_o(qo_rd));

  // response straight from the scheduler registers, stable while waiting
  always_comb begin
    rsp.run_task    = cv_q ? 6'(cur_q) : 6'd0;
    rsp.run_valid   = cv_q;
    rsp.switched    = sw_q;
    rsp.no_runnable = none_q;
  end

  assign req_i.ready = (st_q == S_IDLE);
  assign rsp_o.valid = (st_q == S_OUT);
  assign rsp_o.data  = rsp;

  // sequencer
  always_comb begin
    logic [1:0] nst;
    logic [IW-1:0] idw;
    logic idok;
    st_d = st_q; act_d = act_q; rq_d = rq_q; t_d = t_q;
    p_d = p_q; n_d = n_q; tqo_d = tqo_q;
    head_d = head_q; tail_d = tail_q; sel_d = sel_q; aq_d = aq_q;
    pass_d = pass_q; cnt_d = cnt_q; slice_d = slice_q; cur_d = cur_q;
    cv_d = cv_q; sw_d = sw_q; none_d = none_q;
    st_we = 1'b0; pr_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; qo_we = 1'b0;
    st_wa = t_q; st_wd = tlwrr_pkg::ST_FREE; nx_wa = t_q; nx_wd = NIL;
    pv_wa = t_q; pv_wd = NIL; qo_wd = aq_q; ra = t_q;
    nst = (rq_q.new_status == 2'd3) ? tlwrr_pkg::ST_STOP : rq_q.new_status;
    idw = IW'(rq_q.task_id);
    idok = ({26'd0, rq_q.task_id} < 32'(MAX_TASKS));
    unique case (st_q)
      S_CLR: begin
        st_we = 1'b1; st_wa = cnt_q[IW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (LW+1)'(MAX_TASKS - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_i.valid) begin
          rq_d = req_i.data; sw_d = 1'b0; none_d = 1'b0;
          st_d = (req_i.data.func == tlwrr_pkg::FUNC_TICK) ? S_DEC : S_RD;
          t_d = IW'(req_i.data.task_id);
          ra = IW'(req_i.data.task_id);
        end
      end
      S_DEC: begin
        if (slice_q > SMIN) slice_d = slice_q - SW'(1);
        pass_d = 1'b0; cnt_d = '0;
        if (!cv_q) st_d = S_WHD;
        else begin t_d = cur_q; ra = cur_q; st_d = S_CHK; end
      end
      S_CHK: begin ra = t_q; st_d = S_CHKW; end
      S_CHKW: begin
        if (slice_q > 0 && st_rd == tlwrr_pkg::ST_RUN) st_d = S_OUT;
        else st_d = S_WHD;
      end
      S_WHD: begin
        // examine head of selected queue
        if (head_q[sel_q] == NIL || cnt_q > (LW+1)'(MAX_TASKS)) begin
          if (!pass_q) begin
            pass_d = 1'b1; cnt_d = '0;
            if (head_q[sel_q] == NIL) sel_d = ~sel_q;
          end else begin
            cv_d = 1'b0; none_d = 1'b1; st_d = S_OUT;
          end
        end else begin
          t_d = head_q[sel_q][IW-1:0]; st_d = S_WST;
        end
      end
      S_WST: begin ra = t_q; st_d = S_WSW; end
      S_WSW: begin
        cnt_d = cnt_q + 1'b1;
        act_d = (st_rd == tlwrr_pkg::ST_RUN) ? A_PICK : A_WALK;
        aq_d = ~sel_q;
        p_d = pv_rd; n_d = nx_rd; tqo_d = qo_rd;
        st_d = S_UL1;
      end
      S_RD: begin
        ra = t_q; st_d = S_RDW;
        act_d = A_REM;
        if (!idok) st_d = S_OUT;
      end
      S_RDW: begin
        p_d = pv_rd; n_d = nx_rd; tqo_d = qo_rd;
        st_d = S_OUT;
        if (rq_q.func == tlwrr_pkg::FUNC_INSERT && nst != tlwrr_pkg::ST_FREE) begin
          act_d = A_INS; aq_d = rq_q.target_queue ? ~sel_q : sel_q;
          st_d = (st_rd != tlwrr_pkg::ST_FREE) ? S_UL1 : S_AP1;
        end else if (rq_q.func == tlwrr_pkg::FUNC_STATUS &&
                     nst != tlwrr_pkg::ST_FREE) begin
          if (st_rd != tlwrr_pkg::ST_FREE) begin
            st_we = 1'b1; st_wd = nst;
          end
        end else begin
          act_d = A_REM;
          if (st_rd != tlwrr_pkg::ST_FREE) st_d = S_UL1;
          else st_we = 1'b1;
          if (cv_q && cur_q == idw) cv_d = 1'b0;
        end
      end
      S_UL1: begin
        if (p_q != NIL) begin nx_we = 1'b1; nx_wa = p_q[IW-1:0]; nx_wd = n_q; end
        else head_d[tqo_q] = n_q;
        st_d = S_UL2;
      end
      S_UL2: begin
        if (n_q != NIL) begin pv_we = 1'b1; pv_wa = n_q[IW-1:0]; pv_wd = p_q; end
        else tail_d[tqo_q] = p_q;
        if (act_q == A_REM) begin
          st_we = 1'b1; st_d = S_OUT;
        end else st_d = S_AP1;
      end
      S_AP1: begin
        pv_we = 1'b1; pv_wd = tail_q[aq_q];
        nx_we = 1'b1; nx_wd = NIL; qo_we = 1'b1;
        if (act_q == A_INS) begin
          pr_we = 1'b1; st_we = 1'b1; st_wd = nst;
        end
        st_d = S_AP2;
      end
      S_AP2: begin
        if (tail_q[aq_q] != NIL) begin
          nx_we = 1'b1; nx_wa = tail_q[aq_q][IW-1:0]; nx_wd = {1'b0, t_q};
        end else head_d[aq_q] = {1'b0, t_q};
        tail_d[aq_q] = {1'b0, t_q};
        if (act_q == A_WALK) st_d = S_WHD;
        else if (act_q == A_PICK) begin
          // picked task becomes current, fetch its priority
          ra = t_q; cur_d = t_q; cv_d = 1'b1; sw_d = 1'b1;
          st_d = S_PRIO;
        end else st_d = S_OUT;
      end
      S_PRIO: begin
        // reload the slice counter
        slice_d = $signed({1'b0, pr_rd});
        st_d = S_OUT;
      end
      S_OUT: begin
        if (rsp_o.ready) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; cnt_q <= '0; sel_q <= 1'b0; slice_q <= '0;
      cur_q <= '0; cv_q <= 1'b0; head_q[0] <= NIL; head_q[1] <= NIL;
      tail_q[0] <= NIL; tail_q[1] <= NIL; sw_q <= 1'b0; none_q <= 1'b0;
      pass_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; sel_q <= sel_d; slice_q <= slice_d;
      cur_q <= cur_d; cv_q <= cv_d; head_q <= head_d; tail_q <= tail_d;
      sw_q <= sw_d; none_q <= none_d; pass_q <= pass_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q <= act_d; rq_q <= rq_d; t_q <= t_d; p_q <= p_d; n_q <= n_d;
    tqo_q <= tqo_d; aq_q <= aq_d;
  end
endmodule
